>>> sv/rcv_pkg.sv
// shared types and register codes for the 3x3 rgb convolution unit
// no dependencies
package rcv_pkg;

  typedef logic [23:0] pixel_t;
  typedef pixel_t [8:0] window_t;
  typedef logic [2:0][47:0] kernel_t;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_KERNEL_TOP    = 3'd2,
    REG_KERNEL_MIDDLE = 3'd3,
    REG_KERNEL_BOTTOM = 3'd4
  } cfg_reg_e;

  // one window snapshot plus which output rows and columns it serves
  typedef struct packed {
    window_t win;
    logic    row_main;
    logic    row_edge;
    logic    col_main;
    logic    col_edge;
  } group_t;

  typedef struct packed {
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic [7:0] ch2;
    logic       row_end;
    logic       frame_end;
  } result_t;

  localparam int unsigned HEIGHT_LIMIT = 4096;

endpackage

>>> sv/rgb_conv3x3_edge_replicate_unit.sv
// top level of the streaming 3x3 rgb convolution with replicated borders
// depends on rcv_pkg, rcv_front, rcv_back and rcv_fifo
//
// usage
//   pixels go in raster order on the push/full side, one beat per pixel
//   results come out on the empty/pop side, oldest first, in raster order
//   output (r-1, c-1) is produced once pixel (r, c) is in; the last column
//   and the last row also flush the outstanding border pixels, up to four
//   results for one input
//   configuration goes in on the cfg channel, which is always ready; write
//   only while the unit is idle. a geometry write restarts the frame
// pipeline and rate
//   with idle queues a result reaches the ports, after the edge that takes the
//   pixel causing it, by way of the line store read, the window into the group
//   queue, the products, the sum and the result queue
//   one pixel per cycle while full is low and one result per cycle while the
//   result queue has room; the single result pipeline sets the rate, so rows
//   with extra border results take extra cycles at their ends
// reset
//   positions, window and all queues clear; the line store is not cleared,
//   the first row never reads it
// stalls
//   a result holds on the ports until popped; a short window queue lets the
//   front keep taking pixels while the result side backs up
module rgb_conv3x3_edge_replicate_unit import rcv_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  channel_zero_in_i,
  input  logic [7:0]  channel_one_in_i,
  input  logic [7:0]  channel_two_in_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  channel_zero_out_o,
  output logic [7:0]  channel_one_out_o,
  output logic [7:0]  channel_two_out_o,
  output logic        row_end_o,
  output logic        frame_end_o
);

  logic [10:0] frame_width_q;
  logic [12:0] frame_height_q;
  kernel_t     kernel_q;
  logic        cfg_we, restart;

  group_t  grp_in, grp_head;
  logic    grp_push, grp_pop, grp_full, grp_empty;
  logic [1:0] grp_count;
  result_t res_in, res_head;
  logic    res_push, res_full;
  logic [2:0] res_count;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign restart     = cfg_we && ((cfg_reg_e'(cfg_index_i) == REG_FRAME_WIDTH) ||
                                  (cfg_reg_e'(cfg_index_i) == REG_FRAME_HEIGHT));

  // configuration registers; indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= 11'd640;
      frame_height_q <= 13'd480;
      kernel_q[0]    <= 48'h0;
      kernel_q[1]    <= 48'h0000_0100_0000;
      kernel_q[2]    <= 48'h0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:   frame_width_q  <= cfg_data_i[10:0];
        REG_FRAME_HEIGHT:  frame_height_q <= cfg_data_i[12:0];
        REG_KERNEL_TOP:    kernel_q[0]    <= cfg_data_i;
        REG_KERNEL_MIDDLE: kernel_q[1]    <= cfg_data_i;
        REG_KERNEL_BOTTOM: kernel_q[2]    <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  // front: positions, line store, window
  rcv_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .restart_i      (restart),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .push_i         (push),
    .full_o         (full),
    .pix_i          ({channel_two_in_i, channel_one_in_i, channel_zero_in_i}),
    .grp_push_o     (grp_push),
    .grp_o          (grp_in),
    .grp_full_i     (grp_full)
  );

  // window groups between front and back
  rcv_fifo #(.WIDTH($bits(group_t)), .DEPTH(2)) u_grp_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (grp_push),
    .data_i  (grp_in),
    .pop_i   (grp_pop),
    .data_o  (grp_head),
    .full_o  (grp_full),
    .empty_o (grp_empty),
    .count_o (grp_count)
  );

  // back: multiply, sum, clamp
  rcv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kernel_i    (kernel_q),
    .grp_empty_i (grp_empty),
    .grp_i       (grp_head),
    .grp_pop_o   (grp_pop),
    .out_count_i (res_count),
    .out_push_o  (res_push),
    .out_o       (res_in)
  );

  // result queue, the back reserves room before issuing
  rcv_fifo #(.WIDTH($bits(result_t)), .DEPTH(4)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_head),
    .full_o  (res_full),
    .empty_o (empty),
    .count_o (res_count)
  );

  assign channel_zero_out_o = res_head.ch0;
  assign channel_one_out_o  = res_head.ch1;
  assign channel_two_out_o  = res_head.ch2;
  assign row_end_o          = res_head.row_end && !(res_full && grp_count[1] && 1'b0);
  assign frame_end_o        = res_head.frame_end;

endmodule

>>> sv/rcv_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module rcv_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> sv/rcv_fifo.sv
// small register queue with occupancy count
// no dependencies
module rcv_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wp_q, rp_q;
  logic [$clog2(DEPTH+1)-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == ($clog2(DEPTH+1))'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> sv/rcv_front.sv
// front end: raster position, line store access and 3x3 window build
// depends on rcv_pkg and rcv_ram
module rcv_front import rcv_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        restart_i,
  input  logic [10:0] frame_width_i,
  input  logic [12:0] frame_height_i,
  input  logic        push_i,
  output logic        full_o,
  input  pixel_t      pix_i,
  output logic        grp_push_o,
  output group_t      grp_o,
  input  logic        grp_full_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  logic [WW-1:0] w_eff;
  logic [12:0]   h_eff;
  logic [AW-1:0] col_q;
  logic [11:0]   row_q;
  logic          last_col, last_row, accept;

  logic          s1_valid_q, s1_go;
  pixel_t        s1_pix_q;
  logic [AW-1:0] s1_col_q;
  logic          s1_rz_q, s1_lr_q, s1_c0_q, s1_lc_q;
  logic          fwd_q;
  logic [47:0]   fwd_data_q, rdata, line, wdata;
  pixel_t        top, mid;
  window_t       win_q, win_d;

  always_comb begin
    if (frame_width_i == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width_i) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_i);
    end
    if (frame_height_i == '0) begin
      h_eff = 13'd1;
    end else if (32'(frame_height_i) > HEIGHT_LIMIT) begin
      h_eff = 13'(HEIGHT_LIMIT);
    end else begin
      h_eff = frame_height_i;
    end
  end

  assign last_col = (WW'(col_q) == w_eff - 1'b1);
  assign last_row = ({1'b0, row_q} == h_eff - 1'b1);
  assign s1_go    = s1_valid_q && !grp_full_i;
  assign full_o   = s1_valid_q && !s1_go;
  assign accept   = push_i && !full_o;

  rcv_ram #(.WIDTH(48), .DEPTH(MAX_WIDTH)) u_line (
    .clk_i   (clk_i),
    .we_i    (s1_go),
    .waddr_i (s1_col_q),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rdata)
  );

  // older row in high half
  assign line  = fwd_q ? fwd_data_q : rdata;
  assign top   = s1_rz_q ? s1_pix_q : line[47:24];
  assign mid   = s1_rz_q ? s1_pix_q : line[23:0];
  assign wdata = {mid, s1_pix_q};

  always_comb begin
    pixel_t v;
    win_d = win_q;
    for (int i = 0; i < 3; i++) begin
      v = (i == 0) ? top : (i == 1) ? mid : s1_pix_q;
      if (s1_c0_q) begin
        win_d[i*3]   = v;
        win_d[i*3+1] = v;
      end else begin
        win_d[i*3]   = win_q[i*3+1];
        win_d[i*3+1] = win_q[i*3+2];
      end
      win_d[i*3+2] = v;
    end
  end

  assign grp_o.win      = win_d;
  assign grp_o.row_main = !s1_rz_q;
  assign grp_o.row_edge = s1_lr_q;
  assign grp_o.col_main = !s1_c0_q;
  assign grp_o.col_edge = s1_lc_q;
  assign grp_push_o     = s1_go && (!s1_rz_q || s1_lr_q) && (!s1_c0_q || s1_lc_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q   <= pix_i;
      s1_col_q   <= col_q;
      s1_rz_q    <= (row_q == '0);
      s1_lr_q    <= last_row;
      s1_c0_q    <= (col_q == '0);
      s1_lc_q    <= last_col;
      fwd_q      <= s1_go && (s1_col_q == col_q);
      fwd_data_q <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
      win_q      <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        win_q <= win_d;
      end
      if (restart_i) begin
        col_q <= '0;
        row_q <= '0;
      end else if (accept) begin
        col_q <= last_col ? '0 : col_q + 1'b1;
        if (last_col) begin
          row_q <= last_row ? '0 : row_q + 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/rcv_back.sv
// back end: walks each window group and runs the 3x3 multiply, sum and clamp
// depends on rcv_pkg
module rcv_back import rcv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  kernel_t    kernel_i,
  input  logic       grp_empty_i,
  input  group_t     grp_i,
  output logic       grp_pop_o,
  input  logic [2:0] out_count_i,
  output logic       out_push_o,
  output result_t    out_o
);

  logic busy_q, row_q, col_q;
  logic cur_row, cur_col, issue, done;
  logic [1:0] rs [3];
  logic [1:0] cs [3];

  logic               v0_q, v1_q;
  logic               re0_q, fe0_q, re1_q, fe1_q;
  logic signed [16:0] prod_q [3][9];
  logic signed [20:0] sum_q [3];
  logic signed [16:0] prod_d [3][9];
  logic signed [20:0] sum_d [3];

  // edge row/col is the last one, served by repeating the newest window row or column
  assign cur_row = busy_q ? row_q : !grp_i.row_main;
  assign cur_col = busy_q ? col_q : !grp_i.col_main;
  assign issue   = !grp_empty_i && ((out_count_i + 3'(v0_q) + 3'(v1_q)) < 3'd4);
  assign done    = !(!cur_col && grp_i.col_edge) && !(!cur_row && grp_i.row_edge);
  assign grp_pop_o = issue && done;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rs[k] = cur_row ? ((k == 0) ? 2'd1 : 2'd2) : 2'(k);
      cs[k] = cur_col ? ((k == 0) ? 2'd1 : 2'd2) : 2'(k);
    end
  end

  always_comb begin
    logic signed [24:0] p;
    logic signed [15:0] cf;
    logic [7:0]         px;
    for (int m = 0; m < 3; m++) begin
      for (int k = 0; k < 3; k++) begin
        for (int l = 0; l < 3; l++) begin
          px = grp_i.win[rs[k]*3 + cs[l]][m*8 +: 8];
          cf = $signed(kernel_i[k][l*16 +: 16]);
          p  = cf * $signed({1'b0, px});
          // truncate toward zero
          if (p[24]) begin
            p = (p + 25'sd255) >>> 8;
          end else begin
            p = p >>> 8;
          end
          prod_d[m][k*3+l] = p[16:0];
        end
      end
    end
    for (int m = 0; m < 3; m++) begin
      sum_d[m] = '0;
      for (int i = 0; i < 9; i++) begin
        sum_d[m] = sum_d[m] + 21'(prod_q[m][i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      prod_q <= prod_d;
      re0_q  <= cur_col;
      fe0_q  <= cur_col && cur_row;
    end
    if (v0_q) begin
      sum_q <= sum_d;
      re1_q <= re0_q;
      fe1_q <= fe0_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= 1'b0;
      col_q  <= 1'b0;
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
    end else begin
      v0_q <= issue;
      v1_q <= v0_q;
      if (issue) begin
        if (done) begin
          busy_q <= 1'b0;
        end else if (!cur_col && grp_i.col_edge) begin
          busy_q <= 1'b1;
          row_q  <= cur_row;
          col_q  <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          row_q  <= 1'b1;
          col_q  <= !grp_i.col_main;
        end
      end
    end
  end

  function automatic logic [7:0] clamp8(logic signed [20:0] s);
    if (s < 0) begin
      return 8'd0;
    end else if (s > 21'sd255) begin
      return 8'd255;
    end
    return s[7:0];
  endfunction

  assign out_push_o      = v1_q;
  assign out_o.ch0       = clamp8(sum_q[0]);
  assign out_o.ch1       = clamp8(sum_q[1]);
  assign out_o.ch2       = clamp8(sum_q[2]);
  assign out_o.row_end   = re1_q;
  assign out_o.frame_end = fe1_q;

endmodule

>>> sv/rcv_checker.sv
// port-level checks for the 3x3 rgb convolution unit, bound to the top level
// depends on rgb_conv3x3_edge_replicate_unit
module rcv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [2:0]  cfg_index_i,
  input logic [47:0] cfg_data_i,
  input logic        push,
  input logic        full,
  input logic [7:0]  channel_zero_in_i,
  input logic [7:0]  channel_one_in_i,
  input logic [7:0]  channel_two_in_i,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  channel_zero_out_o,
  input logic [7:0]  channel_one_out_o,
  input logic [7:0]  channel_two_out_o,
  input logic        row_end_o,
  input logic        frame_end_o
);

  // frame end only on the last pixel of a row
  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_end_o) |-> row_end_o)
    else $error("frame end without row end");

  // queues start empty
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result pending during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(channel_zero_out_o) && $stable(channel_two_out_o)
                          && $stable(frame_end_o)))
    else $error("result changed while stalled");

endmodule

bind rgb_conv3x3_edge_replicate_unit rcv_checker u_rcv_checker (.*);

>>> tb/rgb_conv3x3_edge_replicate_unit_tb.sv
// self-checking testbench for rgb_conv3x3_edge_replicate_unit
// holds its own model of the 3x3 filter and compares every result beat with it
// depends on rcv_pkg and the unit under test
module rgb_conv3x3_edge_replicate_unit_tb;
  import rcv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_W = 1024;
  localparam int unsigned SETTLE_CYCLES = 20;
  // an index past the register list, the unit must ignore it
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [47:0] cfg_data_i;
  logic        push;
  logic        full;
  logic [7:0]  channel_zero_in_i;
  logic [7:0]  channel_one_in_i;
  logic [7:0]  channel_two_in_i;
  logic        empty;
  logic        pop;
  logic [7:0]  channel_zero_out_o;
  logic [7:0]  channel_one_out_o;
  logic [7:0]  channel_two_out_o;
  logic        row_end_o;
  logic        frame_end_o;

  rgb_conv3x3_edge_replicate_unit #(.MAX_WIDTH(MAX_W)) DUT (.*);

  // filter state mirrored in the testbench
  logic [10:0]  cur_width;
  logic [12:0]  cur_height;
  kernel_t      cur_kernel;
  logic [47:0]  line_mem [MAX_W];
  pixel_t       win [9];
  int unsigned  col_pos;
  int unsigned  row_pos;

  result_t      pending_pixels [$];
  int           error_count;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit, well above the slowest legal run
  initial begin
    #30ms;
    $display("rgb_conv3x3_edge_replicate_unit_tb: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // reset view of the registers and positions
  function automatic void model_reset();
    cur_width  = 11'd640;
    cur_height = 13'd480;
    cur_kernel[0] = 48'h0;
    cur_kernel[1] = 48'h000001000000;
    cur_kernel[2] = 48'h0;
    foreach (win[i]) win[i] = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic void model_write(input logic [2:0] idx, input logic [47:0] val);
    case (idx)
      REG_FRAME_WIDTH: begin
        cur_width = val[10:0];
        col_pos = 0;
        row_pos = 0;
      end
      REG_FRAME_HEIGHT: begin
        cur_height = val[12:0];
        col_pos = 0;
        row_pos = 0;
      end
      REG_KERNEL_TOP:    cur_kernel[0] = val;
      REG_KERNEL_MIDDLE: cur_kernel[1] = val;
      REG_KERNEL_BOTTOM: cur_kernel[2] = val;
      default: ;
    endcase
  endfunction

  // one output pixel from the window, rs/cs choose rows and columns
  function automatic result_t filter_pixel(input int rs[3], input int cs[3],
                                           input bit rend, input bit fend);
    result_t res;
    int      acc;
    int      coef;
    int      p;
    for (int m = 0; m < 3; m++) begin
      acc = 0;
      for (int k = 0; k < 3; k++)
        for (int l = 0; l < 3; l++) begin
          coef = $signed(cur_kernel[k][16*l +: 16]);
          p = int'(win[rs[k]*3 + cs[l]][8*m +: 8]);
          acc += (coef * p) / 256;  // truncates toward zero
        end
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      case (m)
        0: res.ch0 = acc[7:0];
        1: res.ch1 = acc[7:0];
        default: res.ch2 = acc[7:0];
      endcase
    end
    res.row_end = rend;
    res.frame_end = fend;
    return res;
  endfunction

  // advance the mirror by one accepted pixel and queue what it produces
  function automatic void model_pixel(input pixel_t px);
    int unsigned w, h, c, r, nr, nc, orow[2], ocol[2];
    pixel_t top, mid, v;
    int rsel[2][3];
    int csel[2][3];
    int main_sel[3];
    int edge_sel[3];
    bit rend;
    main_sel = '{0, 1, 2};
    edge_sel = '{1, 2, 2};
    w = cur_width;
    h = cur_height;
    if (w < 1) w = 1;
    if (w > MAX_W) w = MAX_W;
    if (h < 1) h = 1;
    if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    if (r == 0) begin
      top = px;
      mid = px;
    end else begin
      top = line_mem[c][47:24];
      mid = line_mem[c][23:0];
    end
    line_mem[c] = {mid, px};
    for (int i = 0; i < 3; i++) begin
      v = (i == 0) ? top : (i == 1) ? mid : px;
      if (c == 0) begin
        win[i*3] = v;
        win[i*3+1] = v;
      end else begin
        win[i*3] = win[i*3+1];
        win[i*3+1] = win[i*3+2];
      end
      win[i*3+2] = v;
    end
    nr = 0;
    nc = 0;
    if (r >= 1) begin orow[nr] = r - 1; rsel[nr] = main_sel; nr++; end
    if (r == h - 1) begin orow[nr] = r; rsel[nr] = edge_sel; nr++; end
    if (c >= 1) begin ocol[nc] = c - 1; csel[nc] = main_sel; nc++; end
    if (c == w - 1) begin ocol[nc] = c; csel[nc] = edge_sel; nc++; end
    for (int i = 0; i < nr; i++)
      for (int j = 0; j < nc; j++) begin
        rend = (ocol[j] == w - 1);
        pending_pixels.push_back(filter_pixel(rsel[i], csel[j], rend,
                                              rend && (orow[i] == h - 1)));
      end
    if (c == w - 1) begin
      col_pos = 0;
      row_pos = (r == h - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endfunction

  // result side: random pop, compare each beat with the oldest expectation
  always @(negedge clk_i) begin
    if (rst_ni) pop = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected beat count", 1, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (channel_zero_out_o != want.ch0)
          report_mismatch("channel zero", channel_zero_out_o, want.ch0);
        if (channel_one_out_o != want.ch1)
          report_mismatch("channel one", channel_one_out_o, want.ch1);
        if (channel_two_out_o != want.ch2)
          report_mismatch("channel two", channel_two_out_o, want.ch2);
        if (row_end_o != want.row_end)
          report_mismatch("row end", row_end_o, want.row_end);
        if (frame_end_o != want.frame_end)
          report_mismatch("frame end", frame_end_o, want.frame_end);
      end
    end
  end

  // one pixel beat, with a random gap in front of it; push stays high after
  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push = 1'b1;
    {channel_two_in_i, channel_one_in_i, channel_zero_in_i} = px;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    model_pixel(px);
    @(negedge clk_i);
  endtask

  // lets every expected beat drain and the pipeline settle
  task automatic wait_idle();
    push = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    model_write(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h);
    write_reg(REG_FRAME_WIDTH, 48'(w));
    write_reg(REG_FRAME_HEIGHT, 48'(h));
  endtask

  function automatic logic [15:0] random_coef();
    // mostly moderate weights so sums do not always saturate
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(640)) - 320);
  endfunction

  function automatic logic [47:0] random_kernel_row();
    return {random_coef(), random_coef(), random_coef()};
  endfunction

  function automatic pixel_t random_pixel();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return pixel_t'($urandom);
    endcase
  endfunction

  // extremes of the channels, a one-pixel frame and a clamped zero geometry
  task automatic test_single_pixel_frame();
    write_reg(REG_KERNEL_TOP, 48'h0);
    write_reg(REG_KERNEL_MIDDLE, 48'h000001000000);
    write_reg(REG_KERNEL_BOTTOM, 48'h0);
    write_reg(REG_UNUSED, '1);
    set_geometry(0, 0);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h55AA0F);
    wait_idle();
  endtask

  // small frame with negative weights, saturation both ways, truncation of
  // negative products toward zero
  task automatic test_small_frame_kernels();
    set_geometry(3, 2);
    write_reg(REG_KERNEL_TOP, {16'hFFFF, 16'h8000, 16'h7FFF});
    write_reg(REG_KERNEL_MIDDLE, {16'h0100, 16'hFF00, 16'h0180});
    write_reg(REG_KERNEL_BOTTOM, {16'hFF7F, 16'h0001, 16'h0000});
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'hFF00FF);
    send_pixel(24'h00FF00);
    send_pixel(24'h808080);
    send_pixel(24'h7F017F);
    wait_idle();
  endtask

  // one-row frame and one-column frame
  task automatic test_thin_frames();
    set_geometry(4, 1);
    for (int i = 0; i < 4; i++) send_pixel(random_pixel());
    wait_idle();
    set_geometry(1, 3);
    for (int i = 0; i < 3; i++) send_pixel(random_pixel());
    wait_idle();
  endtask

  // width and height above their limits, each cut short by the next restart
  task automatic test_oversize_geometry();
    set_geometry(2047, 1);
    write_reg(REG_KERNEL_TOP, {16'h0020, 16'h0020, 16'h0020});
    write_reg(REG_KERNEL_MIDDLE, {16'h0020, 16'h0040, 16'h0020});
    write_reg(REG_KERNEL_BOTTOM, {16'h0020, 16'h0020, 16'h0020});
    for (int i = 0; i < 40; i++) send_pixel(pixel_t'($urandom));
    wait_idle();
    set_geometry(1, 8191);
    for (int i = 0; i < 40; i++) send_pixel(pixel_t'($urandom));
    wait_idle();
  endtask

  // random frames; some are cut short and restarted by a geometry write
  task automatic test_random_frames(input int unsigned budget, input bit hold_off);
    int unsigned sent, w, h, n;
    bit held;
    sent = 0;
    held = 0;
    while (sent < budget) begin
      w = ($urandom_range(7) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      h = $urandom_range(5, 1);
      set_geometry(w, h);
      if ($urandom_range(2) != 0) begin
        write_reg(REG_KERNEL_TOP, random_kernel_row());
        write_reg(REG_KERNEL_MIDDLE, random_kernel_row());
        write_reg(REG_KERNEL_BOTTOM, random_kernel_row());
      end
      n = w * h;
      if (n > 1 && $urandom_range(5) == 0) n = $urandom_range(n - 1, 1);
      for (int i = 0; i < n; i++) begin
        send_pixel(random_pixel());
        // with hold_off set, the sender holds off once mid-frame until the result side has drained
        if (hold_off && !held && i == n / 2) begin
          push = 1'b0;
          while (pending_pixels.size() != 0) @(posedge clk_i);
          @(negedge clk_i);
          held = 1;
        end
      end
      sent += n;
      wait_idle();
    end
  endtask

  initial begin
    error_count = 0;
    send_idle_pct = 11;
    recv_idle_pct = 75;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_FRAME_WIDTH;
    cfg_data_i = '0;
    push = 1'b0;
    pop = 1'b0;
    channel_zero_in_i = '0;
    channel_one_in_i = '0;
    channel_two_in_i = '0;
    model_reset();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_single_pixel_frame();
    test_small_frame_kernels();
    test_thin_frames();
    test_random_frames(135, 1'b1);

    send_idle_pct = 75;
    recv_idle_pct = 11;
    test_oversize_geometry();
    test_random_frames(135, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(135, 1'b0);

    wait_idle();
    if (error_count == 0) begin
      $display("rgb_conv3x3_edge_replicate_unit_tb: done, clean");
    end else begin
      $display("rgb_conv3x3_edge_replicate_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
